// ----- sv/sqndc_pkg.sv -----
// ----------------------------------------------------------------------------
// sqndc_pkg: shared types and constants for the sprite quad NDC transform
// Holds the CORDIC arctangent table, datapath widths, register indexes and
// the structs passed between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package sqndc_pkg;

  localparam int ANGLE_BITS_DEF = 12;
  localparam int CORDIC_STEPS   = 16;
  localparam int QBITS          = 16;  // quotient bits produced per divide
  localparam int MW             = 36;  // dividend width, signed
  localparam int DW             = 18;  // divisor width
  localparam int FIFO_DEPTH     = 4;

  localparam logic [13:0] RST_SCREEN_W = 14'd1280;
  localparam logic [13:0] RST_SCREEN_H = 14'd720;
  localparam logic [13:0] RST_TEX_W    = 14'd256;
  localparam logic [13:0] RST_TEX_H    = 14'd256;

  // CORDIC gain-compensated start value, Q2.30
  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

  // Arctangent of 2^-i in units of 2^32 per turn
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef enum logic [2:0] {
    REG_SCREEN_W = 3'd0,
    REG_SCREEN_H = 3'd1,
    REG_TEX_W    = 3'd2,
    REG_TEX_H    = 3'd3
  } reg_idx_e;

  typedef struct packed {
    logic [13:0] screen_w;
    logic [13:0] screen_h;
    logic [13:0] tex_w;
    logic [13:0] tex_h;
  } cfg_t;

  typedef struct packed {
    logic signed [17:0] cx;    // centre x, Q.1
    logic signed [17:0] cy;    // centre y, Q.1
    logic [14:0]        dw;
    logic [14:0]        dh;
    logic [16:0]        u0;    // src_left
    logic [16:0]        u1;    // src_left + src_width
    logic [16:0]        v0;
    logic [16:0]        v1;
    logic [31:0]        tint;
  } sprite_t;

  typedef struct packed {
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
    sprite_t            spr;
  } quad_t;

endpackage

// ----- sv/sqndc_if.sv -----
// ----------------------------------------------------------------------------
// sqndc channel interfaces
// Sprite input channel, vertex output channel and register write channel.
// ----------------------------------------------------------------------------
interface sqndc_sprite_if
  import sqndc_pkg::*;
#(
  parameter int AngleBits = ANGLE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   dest_left;
  logic signed [15:0]   dest_top;
  logic [14:0]          dest_width;
  logic [14:0]          dest_height;
  logic [15:0]          src_left;
  logic [15:0]          src_top;
  logic [15:0]          src_width;
  logic [15:0]          src_height;
  logic [AngleBits-1:0] rotation;
  logic [31:0]          tint;

  modport source (
    output valid, dest_left, dest_top, dest_width, dest_height, src_left, src_top,
           src_width, src_height, rotation, tint,
    input  ready
  );
  modport sink (
    input  valid, dest_left, dest_top, dest_width, dest_height, src_left, src_top,
           src_width, src_height, rotation, tint,
    output ready
  );
endinterface

interface sqndc_vertex_if;
  logic               valid;
  logic               ready;
  logic [1:0]         corner;
  logic signed [15:0] ndc_x;
  logic signed [15:0] ndc_y;
  logic [15:0]        tex_u;
  logic [15:0]        tex_v;
  logic [31:0]        vertex_colour;
  logic               last;

  modport source (
    output valid, corner, ndc_x, ndc_y, tex_u, tex_v, vertex_colour, last,
    input  ready
  );
  modport sink (
    input  valid, corner, ndc_x, ndc_y, tex_u, tex_v, vertex_colour, last,
    output ready
  );
endinterface

interface sqndc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [13:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/sqndc_front.sv -----
// ----------------------------------------------------------------------------
// sqndc_front: sprite intake and sine/cosine pipeline
// Takes a sprite per cycle unless stalled by a full queue, runs a 16-stage
// CORDIC on its angle and queues it with its Q1.14 cosine and sine.
// ----------------------------------------------------------------------------
module sqndc_front
  import sqndc_pkg::*;
#(
  parameter int AngleBits = ANGLE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sqndc_sprite_if.sink sprite_i,
  input  logic         q_full_i,
  output logic         push_o,
  output quad_t        push_data_o
);

  localparam int Last = CORDIC_STEPS;

  logic [Last:0]      vld_q;
  logic signed [32:0] x_q    [Last+1];
  logic signed [32:0] y_q    [Last+1];
  logic signed [31:0] z_q    [Last+1];
  logic [1:0]         quad_q [Last+1];
  sprite_t            spr_q  [Last+1];

  logic               en;
  logic [31:0]        ang;
  sprite_t            spr_in;
  logic signed [15:0] cx_r;
  logic signed [15:0] sy_r;

  function automatic logic signed [15:0] to_q14(logic signed [32:0] v);
    logic signed [32:0] r;
    r = (v + 33'sd32768) >>> 16;
    if (r > 33'sd16384) begin
      return 16'sd16384;
    end
    if (r < -33'sd16384) begin
      return -16'sd16384;
    end
    return 16'(r);
  endfunction

  // Stall the whole pipe only when a finished sprite cannot enter the queue
  assign en             = !(vld_q[Last] && q_full_i);
  assign sprite_i.ready = en;
  assign push_o         = vld_q[Last] && !q_full_i;

  always_comb begin
    ang         = 32'(sprite_i.rotation) << (32 - AngleBits);
    spr_in.cx   = {sprite_i.dest_left[15], sprite_i.dest_left, 1'b0}
                + {3'b000, sprite_i.dest_width};
    spr_in.cy   = {sprite_i.dest_top[15], sprite_i.dest_top, 1'b0}
                + {3'b000, sprite_i.dest_height};
    spr_in.dw   = sprite_i.dest_width;
    spr_in.dh   = sprite_i.dest_height;
    spr_in.u0   = {1'b0, sprite_i.src_left};
    spr_in.u1   = 17'(sprite_i.src_left) + 17'(sprite_i.src_width);
    spr_in.v0   = {1'b0, sprite_i.src_top};
    spr_in.v1   = 17'(sprite_i.src_top) + 17'(sprite_i.src_height);
    spr_in.tint = sprite_i.tint;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Last-1:0], sprite_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0]    <= CORDIC_X0;
      y_q[0]    <= '0;
      z_q[0]    <= {2'b00, ang[29:0]};
      quad_q[0] <= ang[31:30];
      spr_q[0]  <= spr_in;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (!z_q[i][31]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN_TAB[i];
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN_TAB[i];
        end
        quad_q[i+1] <= quad_q[i];
        spr_q[i+1]  <= spr_q[i];
      end
    end
  end

  // Round to Q1.14 and fold in the quadrant by exact quarter-turn swaps
  always_comb begin
    cx_r            = to_q14(x_q[Last]);
    sy_r            = to_q14(y_q[Last]);
    push_data_o.spr = spr_q[Last];
    unique case (quad_q[Last])
      2'd0: begin
        push_data_o.cos_v = cx_r;
        push_data_o.sin_v = sy_r;
      end
      2'd1: begin
        push_data_o.cos_v = -sy_r;
        push_data_o.sin_v = cx_r;
      end
      2'd2: begin
        push_data_o.cos_v = -cx_r;
        push_data_o.sin_v = -sy_r;
      end
      default: begin
        push_data_o.cos_v = sy_r;
        push_data_o.sin_v = -cx_r;
      end
    endcase
  end

endmodule

// ----- sv/sqndc_fifo.sv -----
// ----------------------------------------------------------------------------
// sqndc_fifo: sprite queue between front and back end
// Small first-word-fall-through queue of rotated sprites.
// ----------------------------------------------------------------------------
module sqndc_fifo
  import sqndc_pkg::*;
#(
  parameter int Depth = FIFO_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  quad_t data_i,
  input  logic  pop_i,
  output quad_t data_o,
  output logic  full_o,
  output logic  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  quad_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/sqndc_div.sv -----
// ----------------------------------------------------------------------------
// sqndc_div: pipelined floor divider
// Restoring division, one quotient bit per stage. Flags a negative dividend
// and a quotient that does not fit in QBITS bits.
// ----------------------------------------------------------------------------
module sqndc_div
  import sqndc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [MW-1:0] m_i,
  input  logic [DW-1:0]        d_i,
  output logic [QBITS-1:0]     q_o,
  output logic                 neg_o,
  output logic                 ovf_o
);

  localparam int HiW = MW - QBITS;

  logic [DW-1:0]    r_q   [QBITS+1];
  logic [QBITS-1:0] lo_q  [QBITS+1];
  logic [QBITS-1:0] quo_q [QBITS+1];
  logic [DW-1:0]    d_q   [QBITS+1];
  logic             neg_q [QBITS+1];
  logic             ovf_q [QBITS+1];

  logic [HiW-1:0]   hi;
  logic [DW:0]      t_d   [QBITS];
  logic [DW-1:0]    r_d   [QBITS];
  logic             qb_d  [QBITS];

  assign hi = m_i[MW-1:QBITS];

  always_comb begin
    for (int i = 0; i < QBITS; i++) begin
      t_d[i] = {r_q[i], lo_q[i][QBITS-1]};
      if (t_d[i] >= {1'b0, d_q[i]}) begin
        r_d[i]  = DW'(t_d[i] - {1'b0, d_q[i]});
        qb_d[i] = 1'b1;
      end else begin
        r_d[i]  = t_d[i][DW-1:0];
        qb_d[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= hi[DW-1:0];
      lo_q[0]  <= m_i[QBITS-1:0];
      quo_q[0] <= '0;
      d_q[0]   <= d_i;
      neg_q[0] <= m_i[MW-1];
      ovf_q[0] <= !m_i[MW-1] && (hi >= HiW'(d_i));
      for (int i = 0; i < QBITS; i++) begin
        r_q[i+1]   <= r_d[i];
        lo_q[i+1]  <= {lo_q[i][QBITS-2:0], 1'b0};
        quo_q[i+1] <= {quo_q[i][QBITS-2:0], qb_d[i]};
        d_q[i+1]   <= d_q[i];
        neg_q[i+1] <= neg_q[i];
        ovf_q[i+1] <= ovf_q[i];
      end
    end
  end

  assign q_o   = quo_q[QBITS];
  assign neg_o = neg_q[QBITS];
  assign ovf_o = ovf_q[QBITS];

endmodule

// ----- sv/sqndc_back.sv -----
// ----------------------------------------------------------------------------
// sqndc_back: corner sequencer and NDC/texture datapath
// Expands each queued sprite into four corners, one per cycle when unstalled,
// rotates, divides by viewport and texture sizes and registers each vertex.
// ----------------------------------------------------------------------------
module sqndc_back
  import sqndc_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfg_t           cfg_i,
  input  quad_t          head_i,
  input  logic           empty_i,
  output logic           pop_o,
  sqndc_vertex_if.source vertex_o
);

  localparam int Lat = QBITS + 1;

  logic       en;
  logic       issue;
  logic [1:0] k_q;

  // issue stage
  logic               a_vld_q;
  logic [1:0]         a_k_q;
  logic signed [15:0] a_cos_q, a_sin_q, a_ox_q, a_oy_q;
  logic signed [17:0] a_cx_q, a_cy_q;
  logic [16:0]        a_tu_q, a_tv_q;
  logic [31:0]        a_tint_q;
  logic signed [15:0] ox, oy;

  // multiply stage
  logic               b_vld_q;
  logic [1:0]         b_k_q;
  logic signed [31:0] b_cox_q, b_soy_q, b_sox_q, b_coy_q;
  logic signed [17:0] b_cx_q, b_cy_q;
  logic [16:0]        b_tu_q, b_tv_q;
  logic [31:0]        b_tint_q;

  // divider operands
  logic [13:0]        w_e, h_e, tw_e, th_e;
  logic signed [MW-1:0] mx, my, mu, mv;
  logic [DW-1:0]      dx, dy, du, dv;

  // sideband alongside the dividers
  logic        sb_vld_q  [Lat];
  logic [1:0]  sb_k_q    [Lat];
  logic [31:0] sb_tint_q [Lat];

  logic [QBITS-1:0] qx, qy, qu, qv;
  logic             nx, ny, nu, nv;
  logic             ox_f, oy_f, ou_f, ov_f;

  logic               out_vld_q;
  logic [1:0]         out_k_q;
  logic signed [15:0] out_x_q, out_y_q;
  logic [15:0]        out_u_q, out_v_q;
  logic [31:0]        out_tint_q;

  assign en    = !out_vld_q || vertex_o.ready;
  assign issue = en && !empty_i;
  assign pop_o = issue && (k_q == 2'd3);

  always_comb begin
    ox = k_q[0] ? signed'({1'b0, head_i.spr.dw}) : -signed'({1'b0, head_i.spr.dw});
    oy = k_q[1] ? signed'({1'b0, head_i.spr.dh}) : -signed'({1'b0, head_i.spr.dh});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < Lat; i++) begin
        sb_vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      if (issue) begin
        k_q <= k_q + 2'd1;
      end
      a_vld_q     <= issue;
      b_vld_q     <= a_vld_q;
      sb_vld_q[0] <= b_vld_q;
      for (int i = 1; i < Lat; i++) begin
        sb_vld_q[i] <= sb_vld_q[i-1];
      end
      out_vld_q <= sb_vld_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_k_q    <= k_q;
      a_cos_q  <= head_i.cos_v;
      a_sin_q  <= head_i.sin_v;
      a_ox_q   <= ox;
      a_oy_q   <= oy;
      a_cx_q   <= head_i.spr.cx;
      a_cy_q   <= head_i.spr.cy;
      a_tu_q   <= k_q[0] ? head_i.spr.u1 : head_i.spr.u0;
      a_tv_q   <= k_q[1] ? head_i.spr.v1 : head_i.spr.v0;
      a_tint_q <= head_i.spr.tint;

      b_k_q    <= a_k_q;
      b_cox_q  <= a_cos_q * a_ox_q;
      b_soy_q  <= a_sin_q * a_oy_q;
      b_sox_q  <= a_sin_q * a_ox_q;
      b_coy_q  <= a_cos_q * a_oy_q;
      b_cx_q   <= a_cx_q;
      b_cy_q   <= a_cy_q;
      b_tu_q   <= a_tu_q;
      b_tv_q   <= a_tv_q;
      b_tint_q <= a_tint_q;

      sb_k_q[0]    <= b_k_q;
      sb_tint_q[0] <= b_tint_q;
      for (int i = 1; i < Lat; i++) begin
        sb_k_q[i]    <= sb_k_q[i-1];
        sb_tint_q[i] <= sb_tint_q[i-1];
      end
    end
  end

  // Bias the dividends so that each quotient lands in [0, 2^16) when in range
  always_comb begin
    w_e  = (cfg_i.screen_w == '0) ? 14'd1 : cfg_i.screen_w;
    h_e  = (cfg_i.screen_h == '0) ? 14'd1 : cfg_i.screen_h;
    tw_e = (cfg_i.tex_w == '0) ? 14'd1 : cfg_i.tex_w;
    th_e = (cfg_i.tex_h == '0) ? 14'd1 : cfg_i.tex_h;
    mx = (MW'(b_cx_q) <<< 14) + MW'(b_cox_q) - MW'(b_soy_q)
       + (MW'(w_e) << 18) + (MW'(w_e) << 3);
    my = (MW'(b_cy_q) <<< 14) + MW'(b_sox_q) + MW'(b_coy_q)
       + (MW'(h_e) << 18) - (MW'(h_e) << 3);
    mu = (MW'(b_tu_q) << 11) + MW'(tw_e);
    mv = (MW'(b_tv_q) << 11) + MW'(th_e);
    dx = {w_e, 4'b0000};
    dy = {h_e, 4'b0000};
    du = DW'({tw_e, 1'b0});
    dv = DW'({th_e, 1'b0});
  end

  sqndc_div u_div_x (.clk_i, .en_i(en), .m_i(mx), .d_i(dx), .q_o(qx), .neg_o(nx), .ovf_o(ox_f));
  sqndc_div u_div_y (.clk_i, .en_i(en), .m_i(my), .d_i(dy), .q_o(qy), .neg_o(ny), .ovf_o(oy_f));
  sqndc_div u_div_u (.clk_i, .en_i(en), .m_i(mu), .d_i(du), .q_o(qu), .neg_o(nu), .ovf_o(ou_f));
  sqndc_div u_div_v (.clk_i, .en_i(en), .m_i(mv), .d_i(dv), .q_o(qv), .neg_o(nv), .ovf_o(ov_f));

  // Saturate and unbias into the output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_k_q    <= sb_k_q[Lat-1];
      out_tint_q <= sb_tint_q[Lat-1];
      priority if (nx) begin
        out_x_q <= -16'sd32768;
      end else if (ox_f) begin
        out_x_q <= 16'sd32767;
      end else begin
        out_x_q <= signed'({~qx[15], qx[14:0]});
      end
      priority if (ny) begin
        out_y_q <= 16'sd32767;
      end else if (oy_f) begin
        out_y_q <= -16'sd32768;
      end else begin
        out_y_q <= signed'(16'h7FFF - qy);
      end
      out_u_q <= (nu || ou_f) ? 16'hFFFF : qu;
      out_v_q <= (nv || ov_f) ? 16'hFFFF : qv;
    end
  end

  assign vertex_o.valid         = out_vld_q;
  assign vertex_o.corner        = out_k_q;
  assign vertex_o.ndc_x         = out_x_q;
  assign vertex_o.ndc_y         = out_y_q;
  assign vertex_o.tex_u         = out_u_q;
  assign vertex_o.tex_v         = out_v_q;
  assign vertex_o.vertex_colour = out_tint_q;
  assign vertex_o.last          = (out_k_q == 2'd3);

endmodule

// ----- sv/sprite_quad_rotate_to_ndc.sv -----
// ----------------------------------------------------------------------------
// sprite_quad_rotate_to_ndc: sprite quad rotation to normalized device coords
// Turns one sprite transaction into four vertex transactions (left-top,
// right-top, left-bottom, right-bottom) with rotated NDC position, texture
// coordinates and the tint passed through.
// ----------------------------------------------------------------------------
// The back end emits one vertex per cycle while the vertex side does not
// stall, four vertex transactions per sprite. The front end can take a
// sprite every cycle while the queue has room and parks finished sprites in
// a four-entry queue, so bursts are absorbed until the queue fills. On its
// way to the first vertex a sprite passes 17 CORDIC stages (the first one
// takes the sprite), the queue, issue, multiply and 17 divider stages,
// then the output register.
// The viewport and texture size registers are read live by the back end, so
// write them only while no sprite is in flight. A size of zero acts as one.
// ----------------------------------------------------------------------------
module sprite_quad_rotate_to_ndc
  import sqndc_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  sqndc_sprite_if.sink   sprite_i,
  sqndc_vertex_if.source vertex_o,
  sqndc_cfg_if.sink      cfg_i
);

  cfg_t  cfg_q;
  logic  push;
  quad_t push_data;
  quad_t head;
  logic  q_full;
  logic  q_empty;
  logic  pop;

  // Register writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_w <= RST_SCREEN_W;
      cfg_q.screen_h <= RST_SCREEN_H;
      cfg_q.tex_w    <= RST_TEX_W;
      cfg_q.tex_h    <= RST_TEX_H;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_SCREEN_W: cfg_q.screen_w <= cfg_i.data;
        REG_SCREEN_H: cfg_q.screen_h <= cfg_i.data;
        REG_TEX_W:    cfg_q.tex_w    <= cfg_i.data;
        REG_TEX_H:    cfg_q.tex_h    <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // Front end: accept sprites, compute sine and cosine of the angle.
  sqndc_front #(
    .AngleBits(ANGLE_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .sprite_i,
    .q_full_i   (q_full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  // Hold rotated sprites so either side can stall on its own.
  sqndc_fifo #(
    .Depth(FIFO_DEPTH)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (head),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  // Back end: expand to corners, rotate, divide, saturate.
  sqndc_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i  (cfg_q),
    .head_i (head),
    .empty_i(q_empty),
    .pop_o  (pop),
    .vertex_o
  );

endmodule
